// ----- hdl/sfd_pkg.sv -----
// sfd_pkg: shared types and constants for the sync-framed Fletcher-8 deframer.
// Used by every module under hdl/; depends on nothing.
`default_nettype none

package sfd_pkg;

    localparam int CFG_DATA_W = 16;

    // register indexes on the configuration port
    localparam logic [1:0] CFG_FIRST_SYNC   = 2'd0;
    localparam logic [1:0] CFG_SECOND_SYNC  = 2'd1;
    localparam logic [1:0] CFG_MAX_LENGTH   = 2'd2;
    localparam logic [1:0] CFG_CHECK_ENABLE = 2'd3;

    localparam logic [7:0]  FIRST_SYNC_RST   = 8'hB5;
    localparam logic [7:0]  SECOND_SYNC_RST  = 8'h62;
    localparam logic [15:0] MAX_LENGTH_RST   = 16'd1024;
    localparam logic        CHECK_ENABLE_RST = 1'b1;

    // parser phases
    localparam logic [3:0] PH_HUNT    = 4'd0;
    localparam logic [3:0] PH_SYNC2   = 4'd1;
    localparam logic [3:0] PH_CLASS   = 4'd2;
    localparam logic [3:0] PH_ID      = 4'd3;
    localparam logic [3:0] PH_LEN_LO  = 4'd4;
    localparam logic [3:0] PH_LEN_HI  = 4'd5;
    localparam logic [3:0] PH_PAYLOAD = 4'd6;
    localparam logic [3:0] PH_CHK_A   = 4'd7;
    localparam logic [3:0] PH_CHK_B   = 4'd8;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef struct packed {
        logic [7:0]  first_sync;
        logic [7:0]  second_sync;
        logic [15:0] max_length;
        logic        check_enable;
    } cfg_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  frame_class;
        logic [7:0]  msg_id;
        logic [15:0] frame_length;
        logic [15:0] byte_index;
        logic [7:0]  data_byte;
        logic        last;
        logic        accepted;
    } result_t;

endpackage

`default_nettype wire

// ----- hdl/sfd_cfg.sv -----
// sfd_cfg: configuration register bank, written through a plain write port.
// Depends on sfd_pkg.
`default_nettype none

module sfd_cfg
    import sfd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_sync   <= FIRST_SYNC_RST;
            cfg_reg.second_sync  <= SECOND_SYNC_RST;
            cfg_reg.max_length   <= MAX_LENGTH_RST;
            cfg_reg.check_enable <= CHECK_ENABLE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FIRST_SYNC:   cfg_reg.first_sync   <= cfg_data[7:0];
                CFG_SECOND_SYNC:  cfg_reg.second_sync  <= cfg_data[7:0];
                CFG_MAX_LENGTH:   cfg_reg.max_length   <= cfg_data[15:0];
                CFG_CHECK_ENABLE: cfg_reg.check_enable <= cfg_data[0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- hdl/sfd_parse.sv -----
// sfd_parse: frame state machine and running Fletcher-8 sums; one byte per transfer.
// Depends on sfd_pkg.
`default_nettype none

module sfd_parse
    import sfd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cfg_t       cfg,
    input  wire logic       step,
    input  wire logic [7:0] rx_byte,
    output logic            res_valid,
    output result_t         res
);

    logic [3:0]  phase_reg, phase_next;
    logic [7:0]  class_reg, class_next;
    logic [7:0]  id_reg, id_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] count_reg, count_next;
    logic [7:0]  sum_a_reg, sum_a_next;
    logic [7:0]  sum_b_reg, sum_b_next;
    logic [7:0]  chk_a_reg, chk_a_next;

    logic [7:0]  fold_a, fold_b;
    logic [15:0] len_full;
    logic [15:0] count_inc;
    logic        sums_ok;

    assign fold_a    = sum_a_reg + rx_byte;
    assign fold_b    = sum_b_reg + fold_a;
    assign len_full  = {rx_byte, length_reg[7:0]};
    assign count_inc = count_reg + 16'd1;
    assign sums_ok   = (chk_a_reg == sum_a_reg) && (rx_byte == sum_b_reg);

    always_comb
    begin
        phase_next  = phase_reg;
        class_next  = class_reg;
        id_next     = id_reg;
        length_next = length_reg;
        count_next  = count_reg;
        sum_a_next  = sum_a_reg;
        sum_b_next  = sum_b_reg;
        chk_a_next  = chk_a_reg;
        res_valid   = 1'b0;

        res.kind         = KIND_DATA;
        res.frame_class  = class_reg;
        res.msg_id       = id_reg;
        res.frame_length = length_reg;
        res.byte_index   = count_reg;
        res.data_byte    = rx_byte;
        res.last         = 1'b0;
        res.accepted     = 1'b0;

        case (phase_reg)
            PH_HUNT:
            begin
                if (rx_byte == cfg.first_sync)
                    phase_next = PH_SYNC2;
            end
            PH_SYNC2:
            begin
                if (rx_byte == cfg.second_sync)
                begin
                    sum_a_next = 8'd0;
                    sum_b_next = 8'd0;
                    phase_next = PH_CLASS;
                end
                else if (rx_byte != cfg.first_sync)
                    phase_next = PH_HUNT;
            end
            PH_CLASS:
            begin
                class_next = rx_byte;
                sum_a_next = fold_a;
                sum_b_next = fold_b;
                phase_next = PH_ID;
            end
            PH_ID:
            begin
                id_next    = rx_byte;
                sum_a_next = fold_a;
                sum_b_next = fold_b;
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                length_next = {8'd0, rx_byte};
                sum_a_next  = fold_a;
                sum_b_next  = fold_b;
                phase_next  = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                length_next = len_full;
                sum_a_next  = fold_a;
                sum_b_next  = fold_b;
                count_next  = 16'd0;
                if (len_full > cfg.max_length)
                    phase_next = PH_HUNT;
                else if (len_full == 16'd0)
                    phase_next = PH_CHK_A;
                else
                    phase_next = PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                sum_a_next = fold_a;
                sum_b_next = fold_b;
                res_valid  = 1'b1;
                count_next = count_inc;
                if (count_inc >= length_reg)
                    phase_next = PH_CHK_A;
            end
            PH_CHK_A:
            begin
                chk_a_next = rx_byte;
                phase_next = PH_CHK_B;
            end
            PH_CHK_B:
            begin
                res_valid      = 1'b1;
                res.kind       = KIND_END;
                res.byte_index = 16'd0;
                res.data_byte  = 8'd0;
                res.last       = 1'b1;
                res.accepted   = !cfg.check_enable || sums_ok;
                phase_next     = PH_HUNT;
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            class_reg  <= 8'd0;
            id_reg     <= 8'd0;
            length_reg <= 16'd0;
            count_reg  <= 16'd0;
            sum_a_reg  <= 8'd0;
            sum_b_reg  <= 8'd0;
            chk_a_reg  <= 8'd0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            class_reg  <= class_next;
            id_reg     <= id_next;
            length_reg <= length_next;
            count_reg  <= count_next;
            sum_a_reg  <= sum_a_next;
            sum_b_reg  <= sum_b_next;
            chk_a_reg  <= chk_a_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/sfd_outbuf.sv -----
// sfd_outbuf: result register plus one skid entry; stall upstream comes from a flop.
// Depends on sfd_pkg.
`default_nettype none

module sfd_outbuf
    import sfd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t push_data,
    output logic         full,
    output logic         out_valid,
    input  wire logic    out_stall,
    output result_t      out_data
);

    result_t out_reg;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    skid_valid_reg;
    logic    pop;

    assign pop = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            // push only happens while the skid entry is empty
            if (!out_valid_reg || pop)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
                skid_valid_reg <= 1'b0;
            else
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            if (!out_valid_reg || pop)
                out_reg <= push_data;
            else
                skid_reg <= push_data;
        end
        else if (pop && skid_valid_reg)
            out_reg <= skid_reg;
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

// ----- hdl/sync_frame_deframer_fletcher8_top.sv -----
// Top level of the sync-framed Fletcher-8 deframer.
// Depends on sfd_pkg, sfd_cfg, sfd_parse and sfd_outbuf.
//
// Input channel: one received byte (rx_byte) per transfer, in_valid / in_stall.
// Output channel: at most one result per input byte, out_valid / out_stall.
//   A payload byte gives a result with kind 0 and its index in the payload;
//   the second checksum byte gives a frame-end result (kind 1, last 1) whose
//   accepted flag says the checksum matched or checking is off.
// Config port: cfg_we with cfg_index 0..3 (first_sync, second_sync,
//   max_length, check_enable); a write takes effect on the next byte.
// Throughput: one byte per cycle while in_stall is low. The frame state and
//   Fletcher sums update in the cycle a byte transfers; the result is registered
//   at that edge in the output register, or in the skid when the output is held.
// Receiver stall: results back up into a one-entry skid; in_stall rises only
//   when both the output register and the skid hold results.
// Reset: registers return to 0xB5, 0x62, 1024, checking on; the parser hunts
//   for the first sync byte and the output side is empty.
`default_nettype none

module sync_frame_deframer_fletcher8_top
    import sfd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [7:0]            rx_byte,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       kind,
    output logic [7:0]                 frame_class,
    output logic [7:0]                 msg_id,
    output logic [15:0]                frame_length,
    output logic [15:0]                byte_index,
    output logic [7:0]                 data_byte,
    output logic                       last,
    output logic                       accepted,
    input  wire logic                  cfg_we,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg;
    result_t res;
    result_t out_data;
    logic    res_valid;
    logic    step;
    logic    full;

    assign in_stall = full;
    assign step     = in_valid && !full;

    sfd_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sfd_parse u_parse
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .step      (step),
        .rx_byte   (rx_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    sfd_outbuf u_outbuf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step && res_valid),
        .push_data (res),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign kind         = out_data.kind;
    assign frame_class  = out_data.frame_class;
    assign msg_id       = out_data.msg_id;
    assign frame_length = out_data.frame_length;
    assign byte_index   = out_data.byte_index;
    assign data_byte    = out_data.data_byte;
    assign last         = out_data.last;
    assign accepted     = out_data.accepted;

    // skid holds a result only behind a valid output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("skid entry full while output register empty");

    a_end_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_END) |-> (last && data_byte == 8'd0 && byte_index == 16'd0))
        else $error("frame-end result carries payload fields");

    a_data_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_DATA) |-> (!last && !accepted))
        else $error("payload result marked as frame end");

    // a full skid with a stalled receiver must hold the input off next cycle
    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (in_stall && out_stall) |=> in_stall)
        else $error("skid drained while receiver stalled");

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// tb: self-checking bench for sync_frame_deframer_fletcher8_top.
// Depends on sfd_pkg and the deframer RTL; holds its own byte-level frame model.

module tb;
    import sfd_pkg::*;

    typedef struct packed {
        logic [7:0] b;
        bit         typed;
        result_t    want;
    } dir_row_t;

    localparam result_t NO_RESULT = '0;
    localparam result_t DATA_FF = '{KIND_DATA, 8'h01, 8'h02, 16'd1, 16'd0, 8'hFF, 1'b0, 1'b0};
    localparam result_t END_GOOD = '{KIND_END, 8'h01, 8'h02, 16'd1, 16'd0, 8'h00, 1'b1, 1'b1};
    localparam result_t END_BAD = '{KIND_END, 8'hFF, 8'hFF, 16'd0, 16'd0, 8'h00, 1'b1, 1'b0};

    localparam int DIR_N = 26;
    localparam dir_row_t DIR_TAB [DIR_N] = '{
        // good one-byte frame with payload 0xFF
        '{8'hB5, 1'b0, NO_RESULT}, '{8'h62, 1'b0, NO_RESULT},
        '{8'h01, 1'b0, NO_RESULT}, '{8'h02, 1'b0, NO_RESULT},
        '{8'h01, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT},
        '{8'hFF, 1'b1, DATA_FF},
        '{8'h03, 1'b0, NO_RESULT}, '{8'h0F, 1'b1, END_GOOD},
        // first sync followed by a non-sync byte: back to hunting
        '{8'hB5, 1'b0, NO_RESULT}, '{8'h13, 1'b0, NO_RESULT},
        // repeated first sync, empty payload, wrong checksum
        '{8'hB5, 1'b0, NO_RESULT}, '{8'hB5, 1'b0, NO_RESULT},
        '{8'h62, 1'b0, NO_RESULT}, '{8'hFF, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT},
        '{8'h00, 1'b1, END_BAD},
        // length 0xFFFF is over the limit: frame dropped silently
        '{8'hB5, 1'b0, NO_RESULT}, '{8'h62, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, NO_RESULT}, '{8'hFF, 1'b0, NO_RESULT}
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [7:0]            rx_byte = 8'h00;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  kind;
    logic [7:0]            frame_class;
    logic [7:0]            msg_id;
    logic [15:0]           frame_length;
    logic [15:0]           byte_index;
    logic [7:0]            data_byte;
    logic                  last;
    logic                  accepted;
    logic                  cfg_we = 1'b0;
    logic [1:0]            cfg_index = CFG_FIRST_SYNC;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // model copy of the registers
    logic [7:0]  sync_a_cfg = FIRST_SYNC_RST;
    logic [7:0]  sync_b_cfg = SECOND_SYNC_RST;
    logic [15:0] len_limit = MAX_LENGTH_RST;
    logic        chk_on = CHECK_ENABLE_RST;

    // model copy of the parser state
    logic [3:0]  fr_phase = PH_HUNT;
    logic [7:0]  fr_class = 8'h00;
    logic [7:0]  fr_id = 8'h00;
    logic [15:0] fr_len = 16'h0000;
    logic [15:0] fr_count = 16'h0000;
    logic [7:0]  fl_a = 8'h00;
    logic [7:0]  fl_b = 8'h00;
    logic [7:0]  rx_ck_a = 8'h00;

    result_t expected_q [$];
    int      sent = 0;
    int      results_seen = 0;
    int      ends_pass = 0;
    int      ends_fail = 0;
    int      errors = 0;
    bit      steady = 1'b0;

    sync_frame_deframer_fletcher8_top DUT (.*);

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("Regression FAIL");
        $finish;
    end

    always @(negedge clk)
        out_stall <= !steady && ($urandom_range(0, 99) < 26);

    function automatic void fletcher_fold(input logic [7:0] b);
        fl_a = fl_a + b;
        fl_b = fl_b + fl_a;
    endfunction

    // advance the frame model by one byte; returns 1 when a result is due
    function automatic bit deframe_step(input logic [7:0] b, output result_t r);
        bit hit;
        hit = 1'b0;
        r = '0;
        case (fr_phase)
            PH_HUNT:
                if (b == sync_a_cfg)
                    fr_phase = PH_SYNC2;
            PH_SYNC2:
                if (b == sync_b_cfg)
                begin
                    fl_a = 8'h00;
                    fl_b = 8'h00;
                    fr_phase = PH_CLASS;
                end
                else if (b != sync_a_cfg)
                    fr_phase = PH_HUNT;
            PH_CLASS:
            begin
                fr_class = b;
                fletcher_fold(b);
                fr_phase = PH_ID;
            end
            PH_ID:
            begin
                fr_id = b;
                fletcher_fold(b);
                fr_phase = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                fr_len = {8'h00, b};
                fletcher_fold(b);
                fr_phase = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                fr_len = {b, fr_len[7:0]};
                fletcher_fold(b);
                fr_count = 16'h0000;
                if (fr_len > len_limit)
                    fr_phase = PH_HUNT;
                else if (fr_len == 16'h0000)
                    fr_phase = PH_CHK_A;
                else
                    fr_phase = PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                fletcher_fold(b);
                r.kind = KIND_DATA;
                r.byte_index = fr_count;
                r.data_byte = b;
                hit = 1'b1;
                fr_count = fr_count + 16'd1;
                if (fr_count >= fr_len)
                    fr_phase = PH_CHK_A;
            end
            PH_CHK_A:
            begin
                rx_ck_a = b;
                fr_phase = PH_CHK_B;
            end
            PH_CHK_B:
            begin
                r.kind = KIND_END;
                r.last = 1'b1;
                r.accepted = !chk_on || (rx_ck_a == fl_a && b == fl_b);
                hit = 1'b1;
                fr_phase = PH_HUNT;
            end
            default:
                fr_phase = PH_HUNT;
        endcase
        if (hit)
        begin
            r.frame_class = fr_class;
            r.msg_id = fr_id;
            r.frame_length = fr_len;
        end
        return hit;
    endfunction

    function automatic string show_result(input result_t r);
        return $sformatf("kind=%0d class=%h id=%h len=%0d idx=%0d data=%h last=%0d acc=%0d",
                         r.kind, r.frame_class, r.msg_id, r.frame_length, r.byte_index,
                         r.data_byte, r.last, r.accepted);
    endfunction

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                             input result_t want = NO_RESULT);
        result_t r;
        bit      hit;
        while (!steady && $urandom_range(0, 99) < 26)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        hit = deframe_step(b, r);
        if (typed)
            expected_q = {expected_q, want};
        else if (hit)
            expected_q = {expected_q, r};
        sent++;
        @(negedge clk);
    endtask

    // hold the sender until every expected result is out, then let the pipe settle
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic put_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            CFG_FIRST_SYNC:   sync_a_cfg = val[7:0];
            CFG_SECOND_SYNC:  sync_b_cfg = val[7:0];
            CFG_MAX_LENGTH:   len_limit = val[15:0];
            CFG_CHECK_ENABLE: chk_on = val[0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic load_regs(input logic [7:0] s1, input logic [7:0] s2,
                             input logic [15:0] ml, input logic ce);
        cfg_we <= 1'b1;
        put_reg(CFG_FIRST_SYNC, {8'h00, s1});
        put_reg(CFG_SECOND_SYNC, {8'h00, s2});
        put_reg(CFG_MAX_LENGTH, ml);
        put_reg(CFG_CHECK_ENABLE, {15'd0, ce});
        cfg_we <= 1'b0;
    endtask

    // len is the declared length, body_n the payload bytes actually sent;
    // close adds the checksum pair
    task automatic send_frame(input int len, input int body_n, input bit bad_ck,
                              input bit close);
        logic [7:0]  hdr [4];
        logic [7:0]  sa;
        logic [7:0]  sb;
        logic [7:0]  d;
        logic [15:0] l16;
        l16 = len[15:0];
        hdr[0] = 8'($urandom);
        hdr[1] = 8'($urandom);
        hdr[2] = l16[7:0];
        hdr[3] = l16[15:8];
        sa = 8'h00;
        sb = 8'h00;
        if (sync_a_cfg != sync_b_cfg && $urandom_range(0, 3) == 0)
            send_byte(sync_a_cfg);
        send_byte(sync_a_cfg);
        send_byte(sync_b_cfg);
        for (int i = 0; i < 4; i++)
        begin
            sa = sa + hdr[i];
            sb = sb + sa;
            send_byte(hdr[i]);
        end
        for (int i = 0; i < body_n; i++)
        begin
            d = 8'($urandom);
            sa = sa + d;
            sb = sb + sa;
            send_byte(d);
        end
        if (close)
        begin
            if (bad_ck)
            begin
                if ($urandom_range(0, 1) == 0)
                    sa = sa ^ 8'($urandom_range(1, 255));
                else
                    sb = sb ^ 8'($urandom_range(1, 255));
            end
            send_byte(sa);
            send_byte(sb);
        end
    endtask

    function automatic int pick_length();
        int cap;
        cap = ($urandom_range(0, 9) == 0) ? 48 : 12;
        if (cap > int'(len_limit))
            cap = int'(len_limit);
        return $urandom_range(0, cap);
    endfunction

    task automatic send_random_chunk();
        int pick;
        int len;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < 68)
        begin
            len = pick_length();
            send_frame(len, len, $urandom_range(0, 3) == 0, 1'b1);
        end
        else if (pick < 78 && len_limit != 16'hFFFF)
            send_frame($urandom_range(int'(len_limit) + 1, 65535), 0, 1'b0, 1'b0);
        else if (pick < 90)
        begin
            // frame cut off inside the payload
            len = $urandom_range(1, 12);
            send_frame(len, $urandom_range(0, len - 1), 1'b0, 1'b0);
        end
        else
        begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++)
                send_byte((i == 0 && $urandom_range(0, 1) == 1) ? sync_a_cfg : 8'($urandom));
        end
    endtask

    task automatic run_phase(input int target);
        int start;
        start = sent;
        while (sent - start < target)
            send_random_chunk();
    endtask

    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;
        bit      bad;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{kind, frame_class, msg_id, frame_length, byte_index, data_byte, last,
                    accepted};
            results_seen++;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t unexpected result: %s", $realtime, show_result(got));
            end
            else
            begin
                want = expected_q.pop_front();
                bad = (got.kind !== want.kind) || (got.frame_class !== want.frame_class) ||
                      (got.msg_id !== want.msg_id) ||
                      (got.frame_length !== want.frame_length) ||
                      (got.byte_index !== want.byte_index) ||
                      (got.data_byte !== want.data_byte) || (got.last !== want.last) ||
                      (got.accepted !== want.accepted);
                if (want.kind == KIND_END)
                begin
                    if (want.accepted)
                        ends_pass++;
                    else
                        ends_fail++;
                end
                if (bad)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("%0t mismatch expected: %s", $realtime, show_result(want));
                        $display("%0t          actual:   %s", $realtime, show_result(got));
                    end
                end
            end
        end
    end

    initial
    begin
        logic [7:0] s1;
        logic [7:0] s2;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIR_N; i++)
            send_byte(DIR_TAB[i].b, DIR_TAB[i].typed, DIR_TAB[i].want);

        // reset settings, with one full drain partway through
        run_phase(50);
        drain_results();
        run_phase(50);

        drain_results();
        load_regs(8'h00, 8'hFF, 16'd16, 1'b0);
        run_phase(110);

        // equal sync values, no length limit, no idling on either side
        drain_results();
        steady = 1'b1;
        load_regs(8'hFF, 8'hFF, 16'hFFFF, 1'b1);
        run_phase(110);
        steady = 1'b0;

        // only empty frames fit
        drain_results();
        s1 = 8'($urandom);
        s2 = 8'($urandom);
        load_regs(s1, s2, 16'd0, 1'b1);
        run_phase(80);

        drain_results();
        s1 = 8'($urandom);
        s2 = 8'($urandom);
        load_regs(s1, s2, 16'($urandom_range(1, 40)), 1'($urandom_range(0, 1)));
        run_phase(110);

        // back to reset values; one long frame reaches the upper index bits
        drain_results();
        load_regs(FIRST_SYNC_RST, SECOND_SYNC_RST, MAX_LENGTH_RST, CHECK_ENABLE_RST);
        send_frame(257, 257, 1'b0, 1'b1);
        run_phase(40);

        drain_results();
        repeat (8) @(posedge clk);
        $display("Sent %0d bytes over six register settings; checked %0d results, %0d frames",
                 sent, results_seen, ends_pass + ends_fail);
        $display("%0d closed good and %0d rejected; %0d mismatches, %0d results still owed",
                 ends_pass, ends_fail, errors, expected_q.size());
        if (errors == 0 && expected_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/sfd_pkg.sv
hdl/sfd_cfg.sv
hdl/sfd_parse.sv
hdl/sfd_outbuf.sv
hdl/sync_frame_deframer_fletcher8_top.sv
tb/sv/tb.sv
